// File: design/rgbrc_pkg.sv
// ----------------------------------------------------------------------------
// rgbrc_pkg: shared types and constants for the rainbow color cycler
// Color width, reset values and the color-wheel phase codes.
// ----------------------------------------------------------------------------
package rgbrc_pkg;

  // Color level width and full-scale value
  localparam int unsigned COLOR_BITS = 8;
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = {COLOR_BITS{1'b1}};

  // Duty fields carry the low byte of a level
  localparam int unsigned DUTY_BITS = 8;

  // Tick counter and speed
  localparam int unsigned TICK_BITS   = 8;
  localparam logic [TICK_BITS-1:0] TICK_MAX    = {TICK_BITS{1'b1}};
  localparam logic [TICK_BITS-1:0] SPEED_RESET = TICK_BITS'(20);
  localparam logic [TICK_BITS-1:0] DELTA_RESET = TICK_BITS'(5);

  // Color-wheel phases; codes 6 and 7 are unused and hold the wheel
  typedef enum logic [2:0] {
    PH_GREEN_UP   = 3'd0,
    PH_RED_DOWN   = 3'd1,
    PH_BLUE_UP    = 3'd2,
    PH_GREEN_DOWN = 3'd3,
    PH_RED_UP     = 3'd4,
    PH_BLUE_DOWN  = 3'd5
  } wheel_phase_t;

endpackage

// File: design/rgb_rainbow_cycler.sv
// Latency: a tick's result is registered and shown the cycle after its transfer.
// Throughput: one tick per clock; a new tick is taken while a result waits
//   to be taken, as long as the output register frees up in the same cycle.
// Reset (rst, synchronous): red full, green and blue off, wheel in green-up,
//   duties zero, tick counter 0, speed 20, speed delta 5, no result pending.
// ----------------------------------------------------------------------------
// rgb_rainbow_cycler: rainbow color-wheel sequencer
// Counts prescaled ticks; on counter overflow latches the colors into the
// duty outputs, steps the wheel one unit and applies new button presses.
// ----------------------------------------------------------------------------
module rgb_rainbow_cycler
  import rgbrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration: speed delta
  input  logic                 cfg_write,
  input  logic [TICK_BITS-1:0] cfg_data,
  // tick input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 faster_pressed,
  input  logic                 slower_pressed,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] red_duty,
  output logic [DUTY_BITS-1:0] green_duty,
  output logic [DUTY_BITS-1:0] blue_duty,
  output logic                 stepped
);

  logic [TICK_BITS-1:0]  speed_delta;
  logic [COLOR_BITS-1:0] red_level, green_level, blue_level;
  logic [COLOR_BITS-1:0] red_level_next, green_level_next, blue_level_next;
  wheel_phase_t          wheel_phase, wheel_phase_next;
  logic [TICK_BITS-1:0]  tick_count, tick_count_next;
  logic [TICK_BITS-1:0]  speed, speed_next;
  logic                  faster_latched, slower_latched;
  logic                  in_fire, update;
  logic                  faster_new, slower_new;

  // Input transfer: the output register is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign update   = (tick_count == TICK_MAX);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_delta <= DELTA_RESET;
    end else if (cfg_write) begin
      speed_delta <= cfg_data;
    end
  end

  // Color wheel: one unit of the current phase
  always_comb begin
    red_level_next   = red_level;
    green_level_next = green_level;
    blue_level_next  = blue_level;
    wheel_phase_next = wheel_phase;
    case (wheel_phase)
      PH_GREEN_UP: begin
        green_level_next = green_level + 1'b1;
        if (green_level_next == COLOR_MAX) wheel_phase_next = PH_RED_DOWN;
      end
      PH_RED_DOWN: begin
        red_level_next = red_level - 1'b1;
        if (red_level_next == '0) wheel_phase_next = PH_BLUE_UP;
      end
      PH_BLUE_UP: begin
        blue_level_next = blue_level + 1'b1;
        if (blue_level_next == COLOR_MAX) wheel_phase_next = PH_GREEN_DOWN;
      end
      PH_GREEN_DOWN: begin
        green_level_next = green_level - 1'b1;
        if (green_level_next == '0) wheel_phase_next = PH_RED_UP;
      end
      PH_RED_UP: begin
        red_level_next = red_level + 1'b1;
        if (red_level_next == COLOR_MAX) wheel_phase_next = PH_BLUE_DOWN;
      end
      PH_BLUE_DOWN: begin
        blue_level_next = blue_level - 1'b1;
        if (blue_level_next == '0) wheel_phase_next = PH_GREEN_UP;
      end
      default: begin
        // unused phase codes hold the wheel
      end
    endcase
  end

  // Button edges and speed; both presses together cancel out
  assign faster_new = faster_pressed && !faster_latched;
  assign slower_new = slower_pressed && !slower_latched;

  always_comb begin
    speed_next = speed;
    if (faster_new) speed_next = speed_next + speed_delta;
    if (slower_new) speed_next = speed_next - speed_delta;
  end

  // Tick counter: count up, reload from speed on overflow
  assign tick_count_next = update ? (TICK_MAX - speed) : (tick_count + 1'b1);

  // Sequencer state, advanced on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      red_level      <= COLOR_MAX;
      green_level    <= '0;
      blue_level     <= '0;
      wheel_phase    <= PH_GREEN_UP;
      tick_count     <= '0;
      speed          <= SPEED_RESET;
      faster_latched <= 1'b0;
      slower_latched <= 1'b0;
    end else if (in_fire) begin
      tick_count <= tick_count_next;
      if (update) begin
        red_level      <= red_level_next;
        green_level    <= green_level_next;
        blue_level     <= blue_level_next;
        wheel_phase    <= wheel_phase_next;
        speed          <= speed_next;
        faster_latched <= faster_pressed;
        slower_latched <= slower_pressed;
      end
    end
  end

  // Result register; the duty outputs double as the duty state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      red_duty   <= '0;
      green_duty <= '0;
      blue_duty  <= '0;
      stepped    <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid <= 1'b1;
        stepped   <= update;
        if (update) begin
          red_duty   <= red_level[DUTY_BITS-1:0];
          green_duty <= green_level[DUTY_BITS-1:0];
          blue_duty  <= blue_level[DUTY_BITS-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A pending result is never overwritten before its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("result overwritten while stalled");

  // Every tick transfer yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("tick transfer without result");

  // An update reloads the counter from the speed it saw
  a_reload: assert property (@(posedge clk) disable iff (rst)
    in_fire && update |=> tick_count == TICK_MAX - $past(speed))
    else $error("tick counter reload mismatch");

  // Duties move only on an update tick
  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !update |=>
      $stable(red_duty) && $stable(green_duty) && $stable(blue_duty) && !stepped)
    else $error("duty changed without update");

  // Speed and button latches change only on an update tick
  a_speed_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && update) |=> $stable(speed) && $stable(faster_latched)
      && $stable(slower_latched))
    else $error("speed changed outside update");
`endif

endmodule

// File: dv/rgb_rainbow_cycler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_rainbow_cycler_tb: self-checking testbench for the rainbow color cycler
// Feeds button-level ticks through the valid/ready input and predicts each
// tick's duty result with an in-bench color-wheel model. Every result is
// compared in order. The run covers speed wrap, held buttons, and several
// delta settings. It also runs a zero-speed sweep that walks the wheel.
// ----------------------------------------------------------------------------
module rgb_rainbow_cycler_tb;
  import rgbrc_pkg::*;

  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RUN_LEN      = 30;

  typedef struct packed {
    logic faster;
    logic slower;
  } tick_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] red;
    logic [DUTY_BITS-1:0] green;
    logic [DUTY_BITS-1:0] blue;
    logic                 stepped;
  } duty_result_t;

  // DUT ports
  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 cfg_write      = 1'b0;
  logic [TICK_BITS-1:0] cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 faster_pressed = 1'b0;
  logic                 slower_pressed = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [DUTY_BITS-1:0] red_duty;
  logic [DUTY_BITS-1:0] green_duty;
  logic [DUTY_BITS-1:0] blue_duty;
  logic                 stepped;

  // Stimulus and expectation stores
  tick_item_t   pending_ticks[$];
  duty_result_t expected_duties[$];
  logic         in_accepted = 1'b0;

  // Idle control
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 75;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  // Color-wheel model state
  logic [COLOR_BITS-1:0] lvl_red, lvl_green, lvl_blue;
  wheel_phase_t          wheel_ph;
  logic [DUTY_BITS-1:0]  duty_red, duty_green, duty_blue;
  logic [TICK_BITS-1:0]  tick_model;
  logic [TICK_BITS-1:0]  speed_model;
  logic [TICK_BITS-1:0]  delta_model;
  logic                  faster_held, slower_held;
  logic [5:0]            phases_seen;

  // Bookkeeping
  int unsigned error_count   = 0;
  int unsigned ticks_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned update_count  = 0;
  int unsigned speed_changes = 0;
  int unsigned cycle_count   = 0;

  rgb_rainbow_cycler DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .faster_pressed (faster_pressed),
    .slower_pressed (slower_pressed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .red_duty       (red_duty),
    .green_duty     (green_duty),
    .blue_duty      (blue_duty),
    .stepped        (stepped)
  );

  always #5 clk = ~clk;

  // Tick model: counter overflow latches duties, steps wheel, applies presses
  task automatic predict_tick(input logic faster, input logic slower,
                              output duty_result_t res);
    logic overflow;
    overflow = (tick_model == TICK_MAX);
    if (overflow) begin
      duty_red   = DUTY_BITS'(lvl_red);
      duty_green = DUTY_BITS'(lvl_green);
      duty_blue  = DUTY_BITS'(lvl_blue);
      case (wheel_ph)
        PH_GREEN_UP: begin
          lvl_green = lvl_green + 1'b1;
          if (lvl_green == COLOR_MAX) wheel_ph = PH_RED_DOWN;
        end
        PH_RED_DOWN: begin
          lvl_red = lvl_red - 1'b1;
          if (lvl_red == '0) wheel_ph = PH_BLUE_UP;
        end
        PH_BLUE_UP: begin
          lvl_blue = lvl_blue + 1'b1;
          if (lvl_blue == COLOR_MAX) wheel_ph = PH_GREEN_DOWN;
        end
        PH_GREEN_DOWN: begin
          lvl_green = lvl_green - 1'b1;
          if (lvl_green == '0) wheel_ph = PH_RED_UP;
        end
        PH_RED_UP: begin
          lvl_red = lvl_red + 1'b1;
          if (lvl_red == COLOR_MAX) wheel_ph = PH_BLUE_DOWN;
        end
        PH_BLUE_DOWN: begin
          lvl_blue = lvl_blue - 1'b1;
          if (lvl_blue == '0) wheel_ph = PH_GREEN_UP;
        end
        default: ;
      endcase
      phases_seen[wheel_ph] = 1'b1;
      tick_model = TICK_MAX - speed_model;
      // a press counts once; it re-arms only after an update sees release
      if (faster) begin
        if (!faster_held) begin
          speed_model = speed_model + delta_model;
          faster_held = 1'b1;
          speed_changes++;
        end
      end else begin
        faster_held = 1'b0;
      end
      if (slower) begin
        if (!slower_held) begin
          speed_model = speed_model - delta_model;
          slower_held = 1'b1;
          speed_changes++;
        end
      end else begin
        slower_held = 1'b0;
      end
      update_count++;
    end else begin
      tick_model = tick_model + 1'b1;
    end
    res.red     = duty_red;
    res.green   = duty_green;
    res.blue    = duty_blue;
    res.stepped = overflow;
  endtask

  // Transfer sampling: check results, then predict newly accepted ticks
  always @(posedge clk) begin : scoreboard
    duty_result_t predicted;
    duty_result_t observed;
    duty_result_t wanted;
    if (rst) begin
      lvl_red     = COLOR_MAX;
      lvl_green   = '0;
      lvl_blue    = '0;
      wheel_ph    = PH_GREEN_UP;
      duty_red    = '0;
      duty_green  = '0;
      duty_blue   = '0;
      tick_model  = '0;
      speed_model = SPEED_RESET;
      faster_held = 1'b0;
      slower_held = 1'b0;
      phases_seen = 6'b000001;
      in_accepted <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        observed = {red_duty, green_duty, blue_duty, stepped};
        results_seen++;
        if (expected_duties.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d s=%0b",
                   $time, observed.red, observed.green, observed.blue, observed.stepped);
        end else begin
          wanted = expected_duties.pop_front();
          if (observed !== wanted) begin
            error_count++;
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d s=%0b act r=%0d g=%0d b=%0d s=%0b",
                     $time, wanted.red, wanted.green, wanted.blue, wanted.stepped,
                     observed.red, observed.green, observed.blue, observed.stepped);
          end
        end
      end
      in_accepted <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_tick(faster_pressed, slower_pressed, predicted);
        expected_duties.push_back(predicted);
        ticks_taken++;
      end
    end
  end

  // Tick driver: holds payload until transfer, idles at random
  always @(negedge clk) begin : tick_driver
    tick_item_t next_tick;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        in_valid       <= 1'b1;
        faster_pressed <= next_tick.faster;
        slower_pressed <= next_tick.slower;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs
  always @(negedge clk) begin : result_receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_ready   <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_duties.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_run(input int unsigned count, input logic faster, input logic slower);
    tick_item_t item;
    item.faster = faster;
    item.slower = slower;
    repeat (count) pending_ticks.push_back(item);
  endtask

  // Wait until every tick is sent and every result has come back
  task automatic wait_all_results();
    while (pending_ticks.size() != 0 || in_valid || expected_duties.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_delta(input logic [TICK_BITS-1:0] value);
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write   <= 1'b0;
    delta_model = value;
  endtask

  // Press/release runs steered to keep speed low so updates come often
  task automatic push_steered(input int unsigned count);
    int unsigned made;
    int unsigned press_len;
    int unsigned gap_len;
    logic        faster;
    logic        slower;
    made = 0;
    while (made < count) begin
      while (pending_ticks.size() > 2) @(negedge clk);
      press_len = $urandom_range(4, 1);
      gap_len   = $urandom_range(4, 1);
      if ($urandom_range(9) == 0) begin
        faster = 1'($urandom);
        slower = 1'($urandom);
      end else if (speed_model >= 128) begin
        faster = 1'b1;
        slower = ($urandom_range(9) == 0);
      end else if (speed_model != 0 && speed_model >= delta_model) begin
        faster = ($urandom_range(9) == 0);
        slower = 1'b1;
      end else begin
        faster = ($urandom_range(3) == 0);
        slower = ($urandom_range(3) == 0);
      end
      push_run(press_len, faster, slower);
      push_run(gap_len, 1'b0, 1'b0);
      made += press_len + gap_len;
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    delta_model = DELTA_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Lead-in to the first overflow; buttons are ignored off-update
    for (k = 0; k < 255; k++) push_run(1, k[0], k[1]);
    // Reset delta: press, held button, release, both at once, slower
    push_run(RUN_LEN, 1'b1, 1'b0);
    push_run(RUN_LEN, 1'b1, 1'b0);
    push_run(RUN_LEN, 1'b0, 1'b0);
    push_run(RUN_LEN, 1'b1, 1'b1);
    push_run(RUN_LEN, 1'b0, 1'b1);
    push_run(RUN_LEN, 1'b0, 1'b0);
    wait_all_results();

    // Max delta: speed wraps past 255 upward, then below 0 downward
    write_delta(TICK_MAX);
    push_run(RUN_LEN, 1'b1, 1'b0);
    push_run(RUN_LEN, 1'b0, 1'b0);
    push_run(RUN_LEN, 1'b0, 1'b1);
    push_run(RUN_LEN, 1'b0, 1'b0);
    wait_all_results();

    // Drop speed to zero so every tick becomes an update
    write_delta(speed_model);
    push_run(RUN_LEN, 1'b0, 1'b1);
    push_run(RUN_LEN, 1'b0, 1'b0);
    wait_all_results();

    // Zero delta: buttons change nothing, wheel sweeps one step per tick;
    // long receiver hold-off backs the block up
    write_delta('0);
    hold_asked = hold_asked + 1;
    for (k = 0; k < 600; k++) push_run(1, 1'($urandom), 1'($urandom));
    wait_all_results();

    // Swap idle ratios, unit delta, steered presses
    send_idle_pct = 75;
    recv_idle_pct = 25;
    write_delta(TICK_BITS'(1));
    push_steered(200);
    wait_all_results();

    // No idling, small random delta
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_delta(TICK_BITS'($urandom_range(3, 2)));
    push_steered(200);
    wait_all_results();

    $display("Covered %0d ticks, %0d results, %0d color updates, %0d speed changes",
             ticks_taken, results_seen, update_count, speed_changes);
    $display("Wheel phases visited (bit per phase): %b, final speed %0d",
             phases_seen, speed_model);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
